// ===== rtl/core/cfeh_pkg.sv =====
// Shared types and constants for the case-folded ELF hash bucket unit.
`default_nettype none

package cfeh_pkg;

	localparam int KEY_W   = 8;
	localparam int ACC_W   = 28;
	localparam int TS_W    = 16;
	localparam int CNT_W   = $clog2(ACC_W + 1);
	localparam int APB_AW  = 2;
	localparam int APB_DW  = 32;

	localparam logic [TS_W-1:0]   TABLE_SIZE_RESET = TS_W'(251);
	localparam logic [KEY_W-1:0]  COMMA_CHAR       = 8'h2C;
	localparam logic [KEY_W-1:0]  UPPER_FIRST      = 8'h41;
	localparam logic [KEY_W-1:0]  UPPER_LAST       = 8'h5A;
	localparam logic [KEY_W-1:0]  CASE_OFFSET      = 8'h20;

	// Byte address of the only register.
	localparam logic [APB_AW-1:0] REG_TABLE_SIZE = '0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} ctrl_state_t;

	// Accumulator and comma flag after the word on the input channel is applied.
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             comma;
	} hash_res_t;

	// Status of the remainder unit.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfeh_if.sv =====
// Handshake interfaces for the key input channel and the bucket result channel.
`default_nettype none

interface cfeh_in_if;
	import cfeh_pkg::*;

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_byte;
	logic             has_byte;
	logic             in_second_string;
	logic             last;

	modport source (output valid, key_byte, has_byte, in_second_string, last, input ready);
	modport sink   (input valid, key_byte, has_byte, in_second_string, last, output ready);
endinterface

interface cfeh_out_if;
	import cfeh_pkg::*;

	logic            valid;
	logic            ready;
	logic [TS_W-1:0] bucket;
	logic            invalid;

	modport source (output valid, bucket, invalid, input ready);
	modport sink   (input valid, bucket, invalid, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cfeh_hash.sv =====
// Per-byte case-folded ELF hash accumulator with comma detection.
`default_nettype none

module cfeh_hash (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic [cfeh_pkg::KEY_W-1:0] key_byte,
	input  wire logic                      has_byte,
	input  wire logic                      in_second_string,
	input  wire logic                      last,
	output cfeh_pkg::hash_res_t            nxt
);
	import cfeh_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic             comma_q;
	logic [KEY_W-1:0] folded;
	logic [31:0]      shifted;
	logic [3:0]       top;

	always_comb begin
		folded = key_byte;
		if (key_byte >= UPPER_FIRST && key_byte <= UPPER_LAST) begin
			folded = key_byte + CASE_OFFSET;
		end
		// The add wraps at 32 bits; the top nibble folds back into bits 7..4.
		shifted = {acc_q, 4'b0000} + {24'b0, folded};
		top     = shifted[31:28];
	end

	always_comb begin
		nxt.acc   = acc_q;
		nxt.comma = comma_q;
		if (has_byte && !comma_q) begin
			if (in_second_string && key_byte == COMMA_CHAR) begin
				nxt.comma = 1'b1;
			end else begin
				nxt.acc = shifted[ACC_W-1:0] ^ {{(ACC_W-8){1'b0}}, top, 4'b0000};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			comma_q <= 1'b0;
		end else if (accept) begin
			if (last) begin
				acc_q   <= '0;
				comma_q <= 1'b0;
			end else begin
				acc_q   <= nxt.acc;
				comma_q <= nxt.comma;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cfeh_div.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module cfeh_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [cfeh_pkg::ACC_W-1:0] dividend,
	input  wire logic [cfeh_pkg::TS_W-1:0]  divisor,
	output cfeh_pkg::div_stat_t            stat,
	output logic      [cfeh_pkg::TS_W-1:0]  remainder
);
	import cfeh_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] dvd_q;
	logic [TS_W-1:0]  rem_q;
	logic [TS_W-1:0]  dsr_q;
	logic [TS_W:0]    trial;
	logic [TS_W:0]    diff;

	// The partial remainder stays below the divisor, so the trial value is below twice it.
	always_comb begin
		trial     = {rem_q, dvd_q[ACC_W-1]};
		diff      = trial - {1'b0, dsr_q};
		remainder = diff[TS_W] ? trial[TS_W-1:0] : diff[TS_W-1:0];
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && cnt_q == CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(ACC_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ACC_W-2:0], 1'b0};
			rem_q <= remainder;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/case_folded_elf_hash_bucket.sv =====
// Top level of the case-folded ELF hash bucket unit: control, register port, result word.
// Words that are not last are taken one per cycle while the sequencer is idle, and hash in
// the cycle they are accepted. A last word sends the 28-bit hash through the bit-serial
// remainder unit into the pending result, then into the output register that drives out
// valid; an invalid key or a zero table size skips the remainder unit. Input is not ready
// from a last word until its result is registered in the output register.
// Asynchronous active-low reset clears the hash, the comma flag, the sequencer and the
// output valid; table_size resets to 251.
`default_nettype none

module case_folded_elf_hash_bucket (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	cfeh_in_if.sink                           in_ch,
	cfeh_out_if.source                        out_ch,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cfeh_pkg::APB_AW-1:0]  paddr,
	input  wire logic [cfeh_pkg::APB_DW-1:0]  pwdata,
	output logic      [cfeh_pkg::APB_DW-1:0]  prdata,
	output logic                              pready
);
	import cfeh_pkg::*;

	ctrl_state_t     state_q, state_d;
	logic [TS_W-1:0] table_size_q;
	logic            in_acc;
	logic            out_free;
	logic            div_start;
	logic            cap_early;
	logic            cap_div;
	logic            push_out;
	logic [TS_W-1:0] res_bucket_q;
	logic            res_invalid_q;
	logic            out_valid_q;
	logic [TS_W-1:0] out_bucket_q;
	logic            out_invalid_q;
	hash_res_t       hres;
	div_stat_t       dstat;
	logic [TS_W-1:0] drem;

	// Register port. Writes complete in the access phase; pready is tied high.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_TABLE_SIZE) ? {{(APB_DW-TS_W){1'b0}}, table_size_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RESET;
		end else if (psel && penable && pwrite && pready && paddr == REG_TABLE_SIZE) begin
			table_size_q <= pwdata[TS_W-1:0];
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	cfeh_hash u_hash (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (in_acc),
		.key_byte         (in_ch.key_byte),
		.has_byte         (in_ch.has_byte),
		.in_second_string (in_ch.in_second_string),
		.last             (in_ch.last),
		.nxt              (hres)
	);

	cfeh_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (hres.acc),
		.divisor   (table_size_q),
		.stat      (dstat),
		.remainder (drem)
	);

	// Sequencer: an invalid key or a zero table size skips the remainder unit and
	// reports bucket zero; otherwise the final hash is reduced bit by bit.
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		cap_early = 1'b0;
		cap_div   = 1'b0;
		push_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_ch.last) begin
					cap_early = 1'b1;
					if (hres.comma || table_size_q == '0) begin
						state_d = ST_HOLD;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (dstat.done) begin
					cap_div = 1'b1;
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					push_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pending result, filled when the key closes or when the remainder is ready.
	always_ff @(posedge clk) begin
		if (cap_early) begin
			res_bucket_q  <= '0;
			res_invalid_q <= hres.comma;
		end else if (cap_div) begin
			res_bucket_q <= drem;
		end
	end

	// Output register: holds a result word until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_bucket_q  <= res_bucket_q;
			out_invalid_q <= res_invalid_q;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.bucket  = out_bucket_q;
	assign out_ch.invalid = out_invalid_q;

	// The remainder unit only runs while the sequencer waits on it.
	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> state_q == ST_DIV)
		else $error("remainder unit busy outside the divide state");

	// A closing word always takes the sequencer out of idle.
	a_last_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_ch.last) |=> state_q != ST_IDLE)
		else $error("last word did not start result generation");

	// An invalid key reports bucket zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_invalid_q) |-> out_bucket_q == '0)
		else $error("invalid key with nonzero bucket");

	// A valid result lies below the table size.
	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_invalid_q && table_size_q != '0) |-> out_bucket_q < table_size_q)
		else $error("bucket not below table size");

endmodule

`default_nettype wire
